/* rtl/core/ncp_pkg.sv */
package ncp_pkg;

  localparam int unsigned ChanW      = 8;
  localparam int unsigned EntryW     = 3 * ChanW;
  localparam int unsigned PairW      = 2 * EntryW;
  localparam int unsigned DistW      = 18;
  localparam int unsigned IdxW       = 4;
  localparam int unsigned MaxEntries = 16;
  localparam int unsigned PairCount  = 8;
  localparam int unsigned CfgIdxW    = 4;
  localparam int unsigned Latency    = 5;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [DistW:0]    key;
    logic [IdxW-1:0]   idx;
  } cand_t;

  function automatic logic [ChanW-1:0] abs_diff(input logic [ChanW-1:0] a,
                                                input logic [ChanW-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  // keep the left candidate unless the right one is strictly nearer
  function automatic cand_t pick(input cand_t a, input cand_t b);
    pick = (b.key < a.key) ? b : a;
  endfunction

endpackage

/* rtl/core/nearest_palette_colour_core.sv */
// Channel   Direction  Handshake                          Payload
// pixel     in         start / busy                       pixel_red_i, pixel_green_i, pixel_blue_i
// result    out        result_valid_o (one-cycle strobe)  nearest_index_o
// config    in         cfg_valid_i / cfg_ready_o          cfg_index_i, cfg_data_i
//
// One pixel per clock; each accepted pixel gives one result strobe at the end of
// the pipeline, which is the three distance stages (difference, square, sum) and the
// two registered halves of the 16-leaf minimum tree.
// Reset clears the palette to black and empties the valid pipeline.
// The receiver cannot stall; busy stays low and cfg_ready_o stays high.
module nearest_palette_colour_core
  import ncp_pkg::*;
#(
  parameter int unsigned NUM_ENTRIES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [ChanW-1:0]   pixel_red_i,
  input  logic [ChanW-1:0]   pixel_green_i,
  input  logic [ChanW-1:0]   pixel_blue_i,
  output logic               result_valid_o,
  output logic [IdxW-1:0]    nearest_index_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [PairW-1:0]   cfg_data_i
);

  localparam int unsigned NumPairs = (NUM_ENTRIES + 1) / 2;

  logic [PairW-1:0]   pair_q [NumPairs];
  logic [Latency-1:0] vld_d, vld_q;
  logic               accept;
  rgb_t               pixel;
  logic [DistW-1:0]   entry_dist [NUM_ENTRIES];

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign pixel       = '{red: pixel_red_i, green: pixel_green_i, blue: pixel_blue_i};

  for (genvar p = 0; p < NumPairs; p++) begin : g_pair
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pair_q[p] <= '0;
      end else if (cfg_valid_i && cfg_ready_o && cfg_index_i == CfgIdxW'(p)) begin
        pair_q[p] <= cfg_data_i;
      end
    end
  end

  for (genvar n = 0; n < NUM_ENTRIES; n++) begin : g_entry
    ncp_dist u_dist (
      .clk_i   (clk_i),
      .pixel_i (pixel),
      .entry_i (rgb_t'(pair_q[n/2][(n%2)*EntryW +: EntryW])),
      .dist_o  (entry_dist[n])
    );
  end

  ncp_min #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_min (
    .clk_i   (clk_i),
    .dist_i  (entry_dist),
    .index_o (nearest_index_o)
  );

  assign vld_d = {vld_q[Latency-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign result_valid_o = vld_q[Latency-1];

endmodule

/* rtl/core/ncp_dist.sv */
module ncp_dist
  import ncp_pkg::*;
(
  input  logic             clk_i,
  input  rgb_t             pixel_i,
  input  rgb_t             entry_i,
  output logic [DistW-1:0] dist_o
);

  logic [ChanW-1:0]   dr_d, dg_d, db_d;
  logic [ChanW-1:0]   dr_q, dg_q, db_q;
  logic [2*ChanW-1:0] sr_d, sg_d, sb_d;
  logic [2*ChanW-1:0] sr_q, sg_q, sb_q;
  logic [DistW-1:0]   dist_d, dist_q;

  always_comb begin
    dr_d   = abs_diff(pixel_i.red, entry_i.red);
    dg_d   = abs_diff(pixel_i.green, entry_i.green);
    db_d   = abs_diff(pixel_i.blue, entry_i.blue);
    sr_d   = dr_q * dr_q;
    sg_d   = dg_q * dg_q;
    sb_d   = db_q * db_q;
    dist_d = DistW'(sr_q) + DistW'(sg_q) + DistW'(sb_q);
  end

  always_ff @(posedge clk_i) begin
    dr_q   <= dr_d;
    dg_q   <= dg_d;
    db_q   <= db_d;
    sr_q   <= sr_d;
    sg_q   <= sg_d;
    sb_q   <= sb_d;
    dist_q <= dist_d;
  end

  assign dist_o = dist_q;

endmodule

/* rtl/core/ncp_min.sv */
module ncp_min
  import ncp_pkg::*;
#(
  parameter int unsigned NUM_ENTRIES = 16
) (
  input  logic             clk_i,
  input  logic [DistW-1:0] dist_i [NUM_ENTRIES],
  output logic [IdxW-1:0]  index_o
);

  cand_t leaf [MaxEntries];
  cand_t lvl1 [MaxEntries/2];
  cand_t lvl2_d [MaxEntries/4];
  cand_t lvl2_q [MaxEntries/4];
  cand_t lvl3 [MaxEntries/8];
  cand_t best_d, best_q;

  for (genvar i = 0; i < MaxEntries; i++) begin : g_leaf
    if (i < NUM_ENTRIES) begin : g_used
      assign leaf[i] = '{key: {1'b0, dist_i[i]}, idx: IdxW'(i)};
    end else begin : g_unused
      assign leaf[i] = '{key: {1'b1, {DistW{1'b0}}}, idx: IdxW'(i)};
    end
  end

  always_comb begin
    for (int i = 0; i < MaxEntries/2; i++) begin
      lvl1[i] = pick(leaf[2*i], leaf[2*i+1]);
    end
    for (int i = 0; i < MaxEntries/4; i++) begin
      lvl2_d[i] = pick(lvl1[2*i], lvl1[2*i+1]);
    end
    for (int i = 0; i < MaxEntries/8; i++) begin
      lvl3[i] = pick(lvl2_q[2*i], lvl2_q[2*i+1]);
    end
    best_d = pick(lvl3[0], lvl3[1]);
  end

  always_ff @(posedge clk_i) begin
    lvl2_q <= lvl2_d;
    best_q <= best_d;
  end

  assign index_o = best_q.idx;

endmodule

/* rtl/core/ncp_checker.sv */
module ncp_checker
  import ncp_pkg::*;
#(
  parameter int unsigned NUM_ENTRIES = 16
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic [ChanW-1:0]   pixel_red_i,
  input logic [ChanW-1:0]   pixel_green_i,
  input logic [ChanW-1:0]   pixel_blue_i,
  input logic               result_valid_o,
  input logic [IdxW-1:0]    nearest_index_o
);

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##5 result_valid_o)
    else $error("missing result after transfer");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, 5))
    else $error("result without matching transfer");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (IdxW+1)'(nearest_index_o) < (IdxW+1)'(NUM_ENTRIES))
    else $error("index beyond palette size");

  a_same_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && $past(result_valid_o)
     && $past(pixel_red_i, 5) == $past(pixel_red_i, 6)
     && $past(pixel_green_i, 5) == $past(pixel_green_i, 6)
     && $past(pixel_blue_i, 5) == $past(pixel_blue_i, 6))
    |-> nearest_index_o == $past(nearest_index_o))
    else $error("equal pixels mapped to different entries");

endmodule

bind nearest_palette_colour_core ncp_checker #(.NUM_ENTRIES(NUM_ENTRIES)) u_ncp_checker (.*);

/* tb/sv/nearest_palette_colour_core_tb.sv */
`timescale 1ns / 1ps

module nearest_palette_colour_core_tb;
  import ncp_pkg::*;

  localparam int unsigned NUM_ENTRIES   = 16;
  localparam int unsigned PixelsPerStep = 210;
  localparam int unsigned StepCount     = 8;
  localparam int unsigned StallLimit    = 1000;
  localparam int unsigned IdlePct[4]    = '{0, 73, 0, 28};

  typedef enum int unsigned {
    PAL_RANDOM,
    PAL_COARSE,
    PAL_WHITE,
    PAL_REPEAT
  } palette_kind_e;

  class nearest_index_board;
    logic [PairW-1:0] pair_q [PairCount];
    logic [IdxW-1:0]  nearest_idx_q [$];
    int unsigned      entries;
    int unsigned      n_errors;

    function new(int unsigned num_entries);
      entries  = num_entries;
      n_errors = 0;
      foreach (pair_q[i]) pair_q[i] = '0;
    endfunction

    function void write_pair(logic [CfgIdxW-1:0] idx, logic [PairW-1:0] data);
      if (idx < PairCount) pair_q[idx] = data;
    endfunction

    function rgb_t entry(int unsigned n);
      return pair_q[n / 2][(n % 2) * EntryW +: EntryW];
    endfunction

    function int unsigned sq_gap(logic [ChanW-1:0] a, logic [ChanW-1:0] b);
      int unsigned d;
      d = (a > b) ? a - b : b - a;
      return d * d;
    endfunction

    function logic [IdxW-1:0] predict_nearest(rgb_t px);
      int unsigned   lim;
      int unsigned   d;
      int unsigned   best_d;
      logic [IdxW-1:0] best;
      rgb_t          e;
      lim    = (entries > MaxEntries) ? MaxEntries : entries;
      best   = '0;
      best_d = 0;
      for (int unsigned n = 0; n < lim; n++) begin
        e = entry(n);
        d = sq_gap(px.red, e.red) + sq_gap(px.green, e.green) + sq_gap(px.blue, e.blue);
        if (n == 0 || d < best_d) begin
          best   = IdxW'(n);
          best_d = d;
        end
      end
      return best;
    endfunction

    function void note_pixel(rgb_t px);
      nearest_idx_q.push_back(predict_nearest(px));
    endfunction

    function void check_index(logic [IdxW-1:0] got);
      logic [IdxW-1:0] exp_idx;
      if (nearest_idx_q.size() == 0) begin
        $display("%0t: unexpected nearest index, expected none, got %0d", $time, got);
        n_errors++;
      end else begin
        exp_idx = nearest_idx_q.pop_front();
        if (got !== exp_idx) begin
          $display("%0t: nearest index mismatch, expected %0d, got %0d",
                   $time, exp_idx, got);
          n_errors++;
        end
      end
    endfunction

    function int unsigned pending();
      return nearest_idx_q.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni          = 1'b0;
  logic               start           = 1'b0;
  logic               busy;
  logic [ChanW-1:0]   pixel_red_i     = '0;
  logic [ChanW-1:0]   pixel_green_i   = '0;
  logic [ChanW-1:0]   pixel_blue_i    = '0;
  logic               result_valid_o;
  logic [IdxW-1:0]    nearest_index_o;
  logic               cfg_valid_i     = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i     = '0;
  logic [PairW-1:0]   cfg_data_i      = '0;

  nearest_index_board board = new(NUM_ENTRIES);
  int unsigned        stall_cycles = 0;

  nearest_palette_colour_core #(
    .NUM_ENTRIES(NUM_ENTRIES)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .pixel_red_i    (pixel_red_i),
    .pixel_green_i  (pixel_green_i),
    .pixel_blue_i   (pixel_blue_i),
    .result_valid_o (result_valid_o),
    .nearest_index_o(nearest_index_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) begin
      board.note_pixel('{red: pixel_red_i, green: pixel_green_i, blue: pixel_blue_i});
    end
    if (rst_ni && result_valid_o) begin
      board.check_index(nearest_index_o);
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_pixel(rgb_t px, int unsigned idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start         <= 1'b1;
    pixel_red_i   <= px.red;
    pixel_green_i <= px.green;
    pixel_blue_i  <= px.blue;
    do @(posedge clk_i); while (busy);
  endtask

  // caller drops cfg_valid_i after the last write of a batch
  task automatic write_pair(logic [CfgIdxW-1:0] idx, logic [PairW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_pair(idx, data);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [ChanW-1:0] pick_level(palette_kind_e kind);
    if (kind == PAL_COARSE) begin
      case ($urandom_range(0, 2))
        0:       return 8'h00;
        1:       return 8'h80;
        default: return 8'hFF;
      endcase
    end
    return ChanW'($urandom_range(0, 255));
  endfunction

  task automatic load_palette(palette_kind_e kind);
    rgb_t             lo;
    rgb_t             hi;
    logic [PairW-1:0] data;
    for (int unsigned k = 0; k < PairCount; k++) begin
      lo = '{red: pick_level(kind), green: pick_level(kind), blue: pick_level(kind)};
      hi = '{red: pick_level(kind), green: pick_level(kind), blue: pick_level(kind)};
      if (kind == PAL_REPEAT && $urandom_range(0, 1) == 1) hi = lo;
      if (kind == PAL_REPEAT && k > 0 && $urandom_range(0, 2) == 0) begin
        lo = board.entry(2 * k - 1);
      end
      data = {hi, lo};
      if (kind == PAL_WHITE) data = '1;
      write_pair(CfgIdxW'(k), data);
    end
    write_pair(CfgIdxW'($urandom_range(PairCount, 2 ** CfgIdxW - 1)),
               PairW'({$urandom, $urandom}));
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [ChanW-1:0] nudge(logic [ChanW-1:0] c);
    int v;
    v = int'(c) + $urandom_range(0, 6) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return ChanW'(v);
  endfunction

  function automatic rgb_t random_pixel();
    rgb_t e;
    e = board.entry($urandom_range(0, NUM_ENTRIES - 1));
    case ($urandom_range(0, 3))
      0, 1: return '{red:   ChanW'($urandom_range(0, 255)),
                     green: ChanW'($urandom_range(0, 255)),
                     blue:  ChanW'($urandom_range(0, 255))};
      2:    return e;
      default: return '{red: nudge(e.red), green: nudge(e.green), blue: nudge(e.blue)};
    endcase
  endfunction

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all-black palette after reset
    send_pixel(24'h000000, 0);
    send_pixel(24'hFFFFFF, 0);
    send_pixel(24'h55AA5A, 0);
    drain();

    write_pair(CfgIdxW'(0), {24'hFFFFFF, 24'h000000});
    write_pair(CfgIdxW'(1), {24'h00FF00, 24'hFF0000});
    write_pair(CfgIdxW'(2), {24'h7F0000, 24'h0000FF});
    write_pair(CfgIdxW'(3), {24'hFF0000, 24'h810000});
    write_pair(CfgIdxW'(4), {24'h404040, 24'h808080});
    write_pair(CfgIdxW'(5), {24'h808080, 24'h404040});
    write_pair(CfgIdxW'(6), {24'hFFFFFF, 24'h000001});
    write_pair(CfgIdxW'(7), {24'h0000FF, 24'h00FF00});
    cfg_valid_i <= 1'b0;
    send_pixel(24'h000000, 0);
    send_pixel(24'hFFFFFF, 0);
    send_pixel(24'hFF0000, 0);
    send_pixel(24'h800000, 0);
    send_pixel(24'h808080, 0);
    send_pixel(24'h404040, 0);
    send_pixel(24'h0000FF, 0);
    send_pixel(24'h000001, 0);
    send_pixel(24'h7F7F7F, 0);
    send_pixel(24'h01FE80, 0);
    send_pixel(24'hFE01FF, 0);
    drain();

    // out-of-range indexes must leave the palette alone
    for (int unsigned k = PairCount; k < 2 ** CfgIdxW; k++) begin
      write_pair(CfgIdxW'(k), '1);
    end
    cfg_valid_i <= 1'b0;
    send_pixel(24'hFF0000, 0);
    send_pixel(24'h0000FE, 0);
    drain();

    write_pair(CfgIdxW'(7), '1);
    write_pair(CfgIdxW'(0), '0);
    cfg_valid_i <= 1'b0;
    send_pixel(24'hFFFFFF, 0);
    send_pixel(24'h000000, 0);
    drain();

    for (int unsigned s = 0; s < StepCount; s++) begin
      load_palette(palette_kind_e'(s % 4));
      repeat (PixelsPerStep) send_pixel(random_pixel(), IdlePct[s % 4]);
      drain();
    end

    repeat (Latency + 3) @(posedge clk_i);
    if (board.n_errors == 0 && board.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
